@@ design/frequency_promote_cache_list_assert.svh @@
// assertion macros for the frequency promote cache list
// used by the top level, no other dependencies
`ifndef FREQUENCY_PROMOTE_CACHE_LIST_ASSERT_SVH
`define FREQUENCY_PROMOTE_CACHE_LIST_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FPCL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FPCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/fpcl_pkg.sv @@
// shared types and constants for the frequency promote cache list
// no dependencies
`timescale 1ns / 1ps

package fpcl_pkg;

  localparam int CAPACITY = 4;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;
  localparam int HC_W     = 16;

  localparam logic [HC_W-1:0] COUNT_MAX    = {HC_W{1'b1}};
  localparam logic [HC_W-1:0] THRESH_RESET = HC_W'(5);

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic             shift_en;
    logic [IDX_W-1:0] upto;
    logic             front_we;
    logic             pos_we;
    logic [IDX_W-1:0] pos;
    logic [HC_W-1:0]  cnt;
  } list_ctl_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] pos;
    logic [HC_W-1:0]  old_cnt;
  } scan_res_t;

endpackage

@@ design/fpcl_list.sv @@
// ordered entry list: keys and hit counters, front first
// depends on fpcl_pkg
`timescale 1ns / 1ps

module fpcl_list (
  input  logic                     clk,
  input  fpcl_pkg::list_ctl_t      ctl,
  input  logic [fpcl_pkg::KEY_W-1:0] wr_key,
  input  logic [fpcl_pkg::IDX_W-1:0] rd_idx,
  output logic [fpcl_pkg::KEY_W-1:0] rd_key,
  output logic [fpcl_pkg::HC_W-1:0]  rd_cnt,
  output logic [fpcl_pkg::KEY_W-1:0] tail_key
);
  import fpcl_pkg::*;

  logic [KEY_W-1:0] keys_r [CAPACITY];
  logic [HC_W-1:0]  cnts_r [CAPACITY];

  always_ff @(posedge clk) begin
    // entry 0 takes the front word or updates its counter in place
    if (ctl.front_we) begin
      keys_r[0] <= wr_key;
      cnts_r[0] <= ctl.cnt;
    end else if (ctl.pos_we && ctl.pos == '0) begin
      cnts_r[0] <= ctl.cnt;
    end
    // later entries shift back by one or update in place
    for (int i = 1; i < CAPACITY; i++) begin
      if (ctl.shift_en && IDX_W'(i) <= ctl.upto) begin
        keys_r[i] <= keys_r[i-1];
        cnts_r[i] <= cnts_r[i-1];
      end else if (ctl.pos_we && ctl.pos == IDX_W'(i)) begin
        cnts_r[i] <= ctl.cnt;
      end
    end
  end

  assign rd_key   = keys_r[rd_idx];
  assign rd_cnt   = cnts_r[rd_idx];
  assign tail_key = keys_r[CAPACITY-1];

endmodule

@@ design/fpcl_scan.sv @@
// key search engine: one shared 64-bit comparator walks the list front to back
// depends on fpcl_pkg
`timescale 1ns / 1ps

module fpcl_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fpcl_pkg::KEY_W-1:0] key,
  input  logic [fpcl_pkg::CNT_W-1:0] total,
  output logic [fpcl_pkg::IDX_W-1:0] rd_idx,
  input  logic [fpcl_pkg::KEY_W-1:0] rd_key,
  input  logic [fpcl_pkg::HC_W-1:0]  rd_cnt,
  output fpcl_pkg::scan_res_t        res
);
  import fpcl_pkg::*;

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [HC_W-1:0]  cnt_r, cnt_nxt;
  logic             match;
  logic             last;
  logic             done;

  assign match = (rd_key == key);
  assign last  = (CNT_W'(idx_r) + CNT_W'(1)) >= total;
  assign done  = busy_r && (match || last);

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    if (start) begin
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end else if (busy_r) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (done) begin
        busy_nxt = 1'b0;
      end
      if (match) begin
        found_nxt = 1'b1;
        pos_nxt   = idx_r;
        cnt_nxt   = rd_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rd_idx      = idx_r;
  assign res.done    = done;
  assign res.found   = found_r;
  assign res.pos     = pos_r;
  assign res.old_cnt = cnt_r;

endmodule

@@ design/frequency_promote_cache_list.sv @@
// top level of the frequency promote cache list: sequencer, threshold, result register
// depends on fpcl_pkg, fpcl_scan, fpcl_list and the assertion header
`timescale 1ns / 1ps

// channel   direction  ports
// in        input      in_valid, in_stall, in_op, in_key
// out       output     out_valid, out_stall, out_hit, out_hit_count, out_evicted,
//                      out_evicted_key, out_occupancy
// cfg       input      cfg_we, cfg_wdata (promote threshold)
//
// an access runs from accept through the search and the list update to the result, and
// the search takes n = 1 to 4 key compares (one per cycle through the single comparator),
// n = 0 on clear or empty list
// the next word is accepted once the list update of the previous one is done
// synchronous active-low reset empties the list and sets the threshold to 5
// a stalled result holds in the output register; a new word may still be taken

module frequency_promote_cache_list (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [fpcl_pkg::KEY_W-1:0] in_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output logic [fpcl_pkg::HC_W-1:0]  out_hit_count,
  output logic                       out_evicted,
  output logic [fpcl_pkg::KEY_W-1:0] out_evicted_key,
  output logic [fpcl_pkg::CNT_W-1:0] out_occupancy,
  input  logic                       cfg_we,
  input  logic [fpcl_pkg::HC_W-1:0]  cfg_wdata
);
  import fpcl_pkg::*;
  `include "frequency_promote_cache_list_assert.svh"

  state_t           state_r, state_nxt;
  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [HC_W-1:0]  thr_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic [HC_W-1:0]  out_hit_count_r, out_hit_count_nxt;
  logic             out_evicted_r, out_evicted_nxt;
  logic [KEY_W-1:0] out_evicted_key_r, out_evicted_key_nxt;
  logic [CNT_W-1:0] out_occupancy_r, out_occupancy_nxt;

  logic             in_acc;
  logic             scan_start;
  logic             upd_go;
  logic             full;
  logic             promote;
  logic             hit_found;
  logic [HC_W-1:0]  newc;

  logic [IDX_W-1:0] rd_idx;
  logic [KEY_W-1:0] rd_key;
  logic [HC_W-1:0]  rd_cnt;
  logic [KEY_W-1:0] tail_key;
  scan_res_t        scan_res;
  list_ctl_t        ctl;

  fpcl_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scan_start),
    .key    (key_r),
    .total  (total_r),
    .rd_idx (rd_idx),
    .rd_key (rd_key),
    .rd_cnt (rd_cnt),
    .res    (scan_res)
  );

  fpcl_list u_list (
    .clk      (clk),
    .ctl      (ctl),
    .wr_key   (key_r),
    .rd_idx   (rd_idx),
    .rd_key   (rd_key),
    .rd_cnt   (rd_cnt),
    .tail_key (tail_key)
  );

  assign in_acc  = in_valid && !in_stall;
  assign full    = total_r >= CNT_W'(CAPACITY);
  assign promote = scan_res.old_cnt >= thr_r;
  // an empty list skips the search, so its found flag is stale
  assign hit_found = scan_res.found && total_r != '0;
  assign newc    = (scan_res.old_cnt == COUNT_MAX) ? COUNT_MAX
                                                   : scan_res.old_cnt + HC_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_op == OP_ACCESS && total_r != '0) ? ST_SCAN : ST_UPDATE;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall   = 1'b1;
    scan_start = 1'b0;
    upd_go     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        scan_start = in_valid && in_op == OP_ACCESS && total_r != '0;
      end
      ST_SCAN: begin
        in_stall = 1'b1;
      end
      ST_UPDATE: begin
        upd_go = !(out_valid_r && out_stall);
      end
      default: in_stall = 1'b1;
    endcase
  end

  // list update and result word
  always_comb begin
    ctl                 = '0;
    total_nxt           = total_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_hit_nxt         = out_hit_r;
    out_hit_count_nxt   = out_hit_count_r;
    out_evicted_nxt     = out_evicted_r;
    out_evicted_key_nxt = out_evicted_key_r;
    out_occupancy_nxt   = out_occupancy_r;
    if (upd_go) begin
      out_valid_nxt       = 1'b1;
      out_hit_nxt         = 1'b0;
      out_hit_count_nxt   = '0;
      out_evicted_nxt     = 1'b0;
      out_evicted_key_nxt = '0;
      priority if (op_r == OP_CLEAR) begin
        total_nxt = '0;
      end else if (hit_found) begin
        out_hit_nxt       = 1'b1;
        out_hit_count_nxt = newc;
        ctl.cnt           = newc;
        if (promote) begin
          ctl.shift_en = 1'b1;
          ctl.upto     = scan_res.pos;
          ctl.front_we = 1'b1;
        end else begin
          ctl.pos_we = 1'b1;
          ctl.pos    = scan_res.pos;
        end
      end else begin
        out_hit_count_nxt = HC_W'(1);
        ctl.cnt           = HC_W'(1);
        ctl.shift_en      = 1'b1;
        ctl.front_we      = 1'b1;
        if (full) begin
          ctl.upto            = IDX_W'(CAPACITY - 1);
          out_evicted_nxt     = 1'b1;
          out_evicted_key_nxt = tail_key;
        end else begin
          ctl.upto  = total_r[IDX_W-1:0];
          total_nxt = total_r + CNT_W'(1);
        end
      end
      out_occupancy_nxt = total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      thr_r       <= THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_op;
      key_r <= in_key;
    end
    out_hit_r         <= out_hit_nxt;
    out_hit_count_r   <= out_hit_count_nxt;
    out_evicted_r     <= out_evicted_nxt;
    out_evicted_key_r <= out_evicted_key_nxt;
    out_occupancy_r   <= out_occupancy_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_hit_count   = out_hit_count_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;
  assign out_occupancy   = out_occupancy_r;

  `FPCL_ASSERT_NOW(a_total_bound, 1'b1, total_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `FPCL_ASSERT_NEXT(a_scan_to_update, state_r == ST_SCAN && scan_res.done, state_r == ST_UPDATE, "search end did not start the update")
  `FPCL_ASSERT_NEXT(a_update_loads_out, upd_go, out_valid_r, "update finished without a result word")
  `FPCL_ASSERT_NOW(a_hit_no_evict, out_valid_r && out_hit_r, !out_evicted_r, "hit reported an eviction")

endmodule
